/* hw/rtl/msw_pkg.sv */
// Shared definitions for the motion sleep/wake detector.
// Register indexes, reset values, field widths and the configuration bundle.
// No dependencies.
package msw_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int REG_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int STILL_OUT_W = 16;
    localparam int OUT_FIELDS_W = 2 + STILL_OUT_W;
    localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_ADDR_W-1:0] REG_STILL_GYRO  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STILL_COUNT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TILT_ACCEL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WAKE_GYRO   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_WAKE_ACCEL  = 3'd4;

    localparam logic [REG_W-1:0] RST_STILL_GYRO  = 16'd30;
    localparam logic [REG_W-1:0] RST_STILL_COUNT = 16'd30;
    localparam logic [REG_W-1:0] RST_TILT_ACCEL  = 16'd75;
    localparam logic [REG_W-1:0] RST_WAKE_GYRO   = 16'd20;
    localparam logic [REG_W-1:0] RST_WAKE_ACCEL  = 16'd50;

    typedef struct packed {
        logic [REG_W-1:0] still_gyro_limit;
        logic [REG_W-1:0] still_count_limit;
        logic [REG_W-1:0] tilt_accel_limit;
        logic [REG_W-1:0] wake_gyro_limit;
        logic [REG_W-1:0] wake_accel_limit;
    } msw_cfg_t;

endpackage

/* hw/rtl/msw_cfg_regs.sv */
// Configuration register file of the motion sleep/wake detector.
// Five 16-bit limits written through a plain write port; uses msw_pkg.
module msw_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [msw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [msw_pkg::REG_W-1:0]         cfg_wdata,
    output msw_pkg::msw_cfg_t                 cfg
);

    msw_pkg::msw_cfg_t cfg_reg;
    msw_pkg::msw_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                msw_pkg::REG_STILL_GYRO:  cfg_next.still_gyro_limit  = cfg_wdata;
                msw_pkg::REG_STILL_COUNT: cfg_next.still_count_limit = cfg_wdata;
                msw_pkg::REG_TILT_ACCEL:  cfg_next.tilt_accel_limit  = cfg_wdata;
                msw_pkg::REG_WAKE_GYRO:   cfg_next.wake_gyro_limit   = cfg_wdata;
                msw_pkg::REG_WAKE_ACCEL:  cfg_next.wake_accel_limit  = cfg_wdata;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.still_gyro_limit  <= msw_pkg::RST_STILL_GYRO;
            cfg_reg.still_count_limit <= msw_pkg::RST_STILL_COUNT;
            cfg_reg.tilt_accel_limit  <= msw_pkg::RST_TILT_ACCEL;
            cfg_reg.wake_gyro_limit   <= msw_pkg::RST_WAKE_GYRO;
            cfg_reg.wake_accel_limit  <= msw_pkg::RST_WAKE_ACCEL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/msw_decide.sv */
// Per-sample decision logic: axis magnitudes, limit compares, next counter and flag.
// Purely combinational; uses msw_pkg for the configuration bundle.
module msw_decide #(
    parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = msw_pkg::COUNT_BITS_DEF
) (
    input  msw_pkg::msw_cfg_t         cfg,
    input  logic [SAMPLE_BITS-1:0]    gyro_x,
    input  logic [SAMPLE_BITS-1:0]    gyro_y,
    input  logic [SAMPLE_BITS-1:0]    gyro_z,
    input  logic [SAMPLE_BITS-1:0]    accel_x,
    input  logic [SAMPLE_BITS-1:0]    accel_y,
    input  logic                      asleep,
    input  logic [COUNT_BITS-1:0]     still_count,
    output logic                      blank_display,
    output logic                      asleep_next,
    output logic [COUNT_BITS-1:0]     still_count_next
);

    localparam int MAG_W   = SAMPLE_BITS + 1;
    localparam int CMP_W   = (MAG_W > msw_pkg::REG_W) ? MAG_W : msw_pkg::REG_W;
    localparam int CCMP_W  = (COUNT_BITS > msw_pkg::REG_W) ? COUNT_BITS : msw_pkg::REG_W;

    function automatic logic [CMP_W-1:0] mag(input logic [SAMPLE_BITS-1:0] v);
        logic [MAG_W-1:0] ext;
        logic [MAG_W-1:0] m;
        ext = {v[SAMPLE_BITS-1], v};
        m   = v[SAMPLE_BITS-1] ? (~ext + 1'b1) : ext;
        return CMP_W'(m);
    endfunction

    logic [CMP_W-1:0]      gx, gy, gz, ax, ay;
    logic [CMP_W-1:0]      still_lim, tilt_lim, wake_g_lim, wake_a_lim;
    logic [CCMP_W-1:0]     count_lim;
    logic                  still;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] count_a;
    logic                  sleep_a;
    logic                  sleep_b;
    logic                  wake;

    always_comb
    begin
        gx = mag(gyro_x);
        gy = mag(gyro_y);
        gz = mag(gyro_z);
        ax = mag(accel_x);
        ay = mag(accel_y);

        still_lim  = CMP_W'(cfg.still_gyro_limit);
        tilt_lim   = CMP_W'(cfg.tilt_accel_limit);
        wake_g_lim = CMP_W'(cfg.wake_gyro_limit);
        wake_a_lim = CMP_W'(cfg.wake_accel_limit);
        count_lim  = CCMP_W'(cfg.still_count_limit);

        still = !asleep && (gx < still_lim) && (gy < still_lim) && (gz < still_lim);

        count_inc = (&still_count) ? still_count : still_count + 1'b1;
        count_a   = still ? count_inc : '0;

        sleep_a = asleep || (still && (CCMP_W'(count_a) > count_lim));
        sleep_b = sleep_a || (ax > tilt_lim) || (ay > tilt_lim);

        wake = sleep_b
            && ((gx > wake_g_lim) || (gy > wake_g_lim) || (gz > wake_g_lim))
            && (ax < wake_a_lim) && (ay < wake_a_lim);

        blank_display    = sleep_b;
        asleep_next      = sleep_b && !wake;
        still_count_next = wake ? '0 : count_a;
    end

endmodule

/* hw/rtl/motion_sleep_wake_detector_core.sv */
// Top level of the motion sleep/wake detector: input register, decision, result register.
// Uses msw_pkg, msw_cfg_regs and msw_decide.
//
// Usage:
//   Motion samples enter on the s_axis channel, one sample per transfer; each
//   sample yields exactly one result transfer on the m_axis channel carrying
//   the display-blank flag, the asleep flag and the stillness counter.
//   Limits are written on the cfg port (cfg_we, cfg_addr, cfg_wdata) while the
//   block is idle; an unknown index is ignored.
// Timing:
//   A sample is captured in the input register on the accepting edge and its
//   result loads into the result register once that register is empty or
//   being read, and is then valid on m_axis. One sample per cycle is sustained
//   while m_axis_tready stays high; the stillness counter and asleep flag
//   update in the same cycle the result register loads.
// Reset:
//   rst_n clears the counter, the asleep flag (awake) and both valid flags,
//   and loads the default limits.
// Stall:
//   While m_axis_tready is low the result holds; the input register still
//   takes one more sample if it is empty, then s_axis_tready drops until the result moves.
module motion_sleep_wake_detector_core #(
    parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = msw_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, zero pad
    input  logic [((5*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // blank_display, sleeping, still_samples[15:0], zero pad
    output logic [msw_pkg::OUT_W-1:0]            m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [msw_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [msw_pkg::REG_W-1:0]            cfg_wdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int DATA_W = 5 * SAMPLE_BITS;
    localparam int CCMP_W = (COUNT_BITS > msw_pkg::STILL_OUT_W) ? COUNT_BITS
                                                                : msw_pkg::STILL_OUT_W;
    localparam int PAD_W  = msw_pkg::OUT_W - msw_pkg::OUT_FIELDS_W;

    msw_pkg::msw_cfg_t cfg;

    logic                   in_valid_reg;
    logic [DATA_W-1:0]      in_data_reg;
    logic                   out_valid_reg;
    logic                   blank_reg;
    logic                   sleeping_reg;
    logic [msw_pkg::STILL_OUT_W-1:0] still_out_reg;
    logic                   asleep_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    logic                   advance;
    logic                   blank_next;
    logic                   asleep_next;
    logic [COUNT_BITS-1:0]  count_next;

    msw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    msw_decide #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_decide (
        .cfg              (cfg),
        .gyro_x           (in_data_reg[0*SB +: SB]),
        .gyro_y           (in_data_reg[1*SB +: SB]),
        .gyro_z           (in_data_reg[2*SB +: SB]),
        .accel_x          (in_data_reg[3*SB +: SB]),
        .accel_y          (in_data_reg[4*SB +: SB]),
        .asleep           (asleep_reg),
        .still_count      (count_reg),
        .blank_display    (blank_next),
        .asleep_next      (asleep_next),
        .still_count_next (count_next)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input stage: hold the sample until it moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata[DATA_W-1:0];
        end
    end

    // Result stage and detector state advance together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            asleep_reg    <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                asleep_reg    <= asleep_next;
                count_reg     <= count_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            blank_reg     <= blank_next;
            sleeping_reg  <= asleep_next;
            still_out_reg <= msw_pkg::STILL_OUT_W'(CCMP_W'(count_next));
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, still_out_reg, sleeping_reg, blank_reg};

endmodule
